@@ rtl/core/dht_pkg.sv @@
package dht_pkg;

    localparam int ENTRY_W   = 10;
    localparam int KEY_W     = 64;
    localparam int KEY_AW    = 10;
    localparam int KEY_DEPTH = 1 << KEY_AW;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ENTRY_W:0]   count_ext_t;

    localparam entry_t     ENTRY_LIMIT_RST = 10'd1023;
    localparam entry_t     ENTRY_EMPTY     = 10'd0;
    localparam count_ext_t ENTRY_MAX       = 11'd1023;

endpackage

@@ rtl/core/dht_if.sv @@
interface dht_cfg_if import dht_pkg::*;;
    logic   valid;
    logic   ready;
    entry_t entry_limit;

    modport source (output valid, output entry_limit, input ready);
    modport sink (input valid, input entry_limit, output ready);
endinterface

interface dht_in_if import dht_pkg::*;;
    logic valid;
    logic ready;
    logic kind;
    key_t hash_key;

    modport source (output valid, output kind, output hash_key, input ready);
    modport sink (input valid, input kind, input hash_key, output ready);
endinterface

interface dht_out_if import dht_pkg::*;;
    logic   valid;
    logic   ready;
    entry_t entry_index;
    logic   was_added;
    logic   table_full;

    modport source (output valid, output entry_index, output was_added, output table_full,
                    input ready);
    modport sink (input valid, input entry_index, input was_added, input table_full,
                  output ready);
endinterface

@@ rtl/core/double_hash_table_find_insert.sv @@
// Channel  Dir  Payload                                Transaction
// -------  ---  -------------------------------------  ------------------
// cfg      in   entry_limit[9:0]                       valid & ready
// req      in   kind, hash_key[63:0]                   valid & ready
// rsp      out  entry_index[9:0], was_added, table_full valid & ready
//
// Each probed slot costs a slot-table read, and an occupied slot also costs a key compare;
// probing ends at an empty slot, at a matching key, or once every slot has been probed.
// After reset the slot table is cleared one slot a cycle while
// req.ready stays low; cfg writes are taken at any time.
// A new request is taken while the previous result waits in the output register;
// the result of that request holds in the finish step until the output register frees.
module double_hash_table_find_insert import dht_pkg::*; #(
    parameter int TABLE_BITS = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    dht_cfg_if.sink   cfg,
    dht_in_if.sink    req,
    dht_out_if.source rsp
);

    localparam longint unsigned TABLE_SIZE = 64'd1 << TABLE_BITS;
    localparam int              EXT_W      = (2 * TABLE_BITS > KEY_W) ? 2 * TABLE_BITS : KEY_W;

    typedef logic [TABLE_BITS-1:0] slot_t;
    typedef logic [EXT_W-1:0]      key_ext_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTRY,
        S_KEY,
        S_FINISH
    } state_t;

    state_t state_reg;
    slot_t  slot_reg;
    slot_t  step_reg;
    slot_t  probes_reg;
    key_t   key_reg;
    logic   kind_reg;
    entry_t entry_reg;
    logic   have_empty_reg;
    entry_t found_reg;
    entry_t count_reg;
    entry_t limit_reg;

    logic   rsp_valid_reg;
    entry_t rsp_index_reg;
    logic   rsp_added_reg;
    logic   rsp_full_reg;

    entry_t slot_mem [0:TABLE_SIZE-1];
    key_t   key_mem [0:KEY_DEPTH-1];
    entry_t slot_rd_reg;
    key_t   key_rd_reg;

    key_ext_t   key_ext_in;
    slot_t      home_slot;
    slot_t      step_in;
    slot_t      slot_adv;
    slot_t      slot_raddr;
    logic       key_match;
    count_ext_t count_inc;
    logic       refuse;
    logic       out_free;
    logic       do_insert;
    logic       slot_we;
    entry_t     slot_wdata;

    assign key_ext_in = EXT_W'(req.hash_key);
    assign home_slot  = key_ext_in[TABLE_BITS-1:0];
    assign step_in    = key_ext_in[2*TABLE_BITS-1:TABLE_BITS] | slot_t'(1);

    // shared probe unit: slot advance and key compare
    assign slot_adv   = slot_reg + step_reg;
    assign slot_raddr = (state_reg == S_IDLE) ? home_slot : slot_adv;
    assign key_match  = (key_rd_reg == key_reg);

    assign count_inc = {1'b0, count_reg} + count_ext_t'(1);
    assign refuse    = !have_empty_reg || (count_inc >= {1'b0, limit_reg})
                       || (count_inc > ENTRY_MAX);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign do_insert = (state_reg == S_FINISH) && out_free && kind_reg
                       && (found_reg == ENTRY_EMPTY) && !refuse;

    assign slot_we    = (state_reg == S_CLEAR) || do_insert;
    assign slot_wdata = (state_reg == S_CLEAR) ? ENTRY_EMPTY : count_inc[ENTRY_W-1:0];

    assign cfg.ready       = 1'b1;
    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.entry_index = rsp_index_reg;
    assign rsp.was_added   = rsp_added_reg;
    assign rsp.table_full  = rsp_full_reg;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_reg] <= slot_wdata;
        end
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            key_mem[count_inc[KEY_AW-1:0]] <= key_reg;
        end
        key_rd_reg <= key_mem[slot_rd_reg[KEY_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            slot_reg       <= '0;
            step_reg       <= '0;
            probes_reg     <= '0;
            key_reg        <= '0;
            kind_reg       <= 1'b0;
            entry_reg      <= ENTRY_EMPTY;
            have_empty_reg <= 1'b0;
            found_reg      <= ENTRY_EMPTY;
            count_reg      <= '0;
            limit_reg      <= ENTRY_LIMIT_RST;
            rsp_valid_reg  <= 1'b0;
            rsp_index_reg  <= ENTRY_EMPTY;
            rsp_added_reg  <= 1'b0;
            rsp_full_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= cfg.entry_limit;
            end

            // drop the taken result unless the finish step refills it
            if (rsp_valid_reg && rsp.ready && (state_reg != S_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    slot_reg <= slot_reg + slot_t'(1);
                    if (slot_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        key_reg        <= req.hash_key;
                        kind_reg       <= req.kind;
                        slot_reg       <= home_slot;
                        step_reg       <= step_in;
                        probes_reg     <= '0;
                        have_empty_reg <= 1'b0;
                        found_reg      <= ENTRY_EMPTY;
                        state_reg      <= S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    entry_reg <= slot_rd_reg;
                    if (slot_rd_reg == ENTRY_EMPTY)
                    begin
                        have_empty_reg <= 1'b1;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_KEY;
                    end
                end
                S_KEY:
                begin
                    priority if (key_match)
                    begin
                        found_reg <= entry_reg;
                        state_reg <= S_FINISH;
                    end
                    else if (probes_reg == '1)
                    begin
                        // every slot visited: key counts as absent, no empty slot
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        slot_reg   <= slot_adv;
                        probes_reg <= probes_reg + slot_t'(1);
                        state_reg  <= S_ENTRY;
                    end
                end
                S_FINISH:
                begin
                    // hold until the output register can take the result
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_added_reg <= do_insert;
                        rsp_full_reg  <= kind_reg && (found_reg == ENTRY_EMPTY) && refuse;
                        if (do_insert)
                        begin
                            rsp_index_reg <= count_inc[ENTRY_W-1:0];
                            count_reg     <= count_inc[ENTRY_W-1:0];
                        end
                        else
                        begin
                            rsp_index_reg <= found_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/dht_checker.sv @@
module dht_checker import dht_pkg::*; (
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input entry_t out_index,
    input logic   out_added,
    input logic   out_full
);

    // a held result keeps its payload until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_index)
                                       && $stable(out_added) && $stable(out_full)))
        else $error("result changed while stalled");

    // one request at a time: ready drops right after a request transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_added && out_full))
        else $error("insert both done and refused");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_full) |-> (out_index == ENTRY_EMPTY))
        else $error("refused insert with nonzero entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_added) |-> (out_index != ENTRY_EMPTY))
        else $error("new entry numbered zero");

endmodule

bind double_hash_table_find_insert dht_checker u_dht_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_index (rsp.entry_index),
    .out_added (rsp.was_added),
    .out_full  (rsp.table_full)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import dht_pkg::*;

    localparam int          TABLE_BITS  = 12;
    localparam int          TABLE_SIZE  = 1 << TABLE_BITS;
    localparam int unsigned TABLE_MASK  = TABLE_SIZE - 1;
    localparam int          PHASES      = 10;
    localparam int          PHASE_ITEMS = 125;
    localparam int          CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        entry_t entry_index;
        logic   was_added;
        logic   table_full;
    } lookup_result_t;

    class table_tracker;
        entry_t         slot_tab [TABLE_SIZE];
        key_t           key_tab [KEY_DEPTH];
        int unsigned    n_entries;
        entry_t         limit;
        lookup_result_t pending_results [$];
        int             mismatches;

        function new();
            foreach (slot_tab[i]) slot_tab[i] = ENTRY_EMPTY;
            foreach (key_tab[i]) key_tab[i] = '0;
            n_entries  = 0;
            limit      = ENTRY_LIMIT_RST;
            mismatches = 0;
        endfunction

        function void set_limit(entry_t value);
            limit = value;
        endfunction

        // Probe with double hashing, then find or insert
        function void note_request(logic kind, key_t key);
            int unsigned    slot;
            int unsigned    step;
            int unsigned    probes;
            int unsigned    next;
            entry_t         e;
            entry_t         found;
            logic           empty_seen;
            lookup_result_t r;
            slot       = key[TABLE_BITS-1:0];
            step       = key[2*TABLE_BITS-1:TABLE_BITS] | 1;
            found      = ENTRY_EMPTY;
            empty_seen = 1'b0;
            r          = '0;
            for (probes = 0; probes < TABLE_SIZE; probes++)
            begin
                e = slot_tab[slot];
                if (e == ENTRY_EMPTY)
                begin
                    empty_seen = 1'b1;
                    break;
                end
                if (key_tab[e] == key)
                begin
                    found = e;
                    break;
                end
                slot = (slot + step) & TABLE_MASK;
            end
            if (found == ENTRY_EMPTY && kind)
            begin
                next = n_entries + 1;
                if (!empty_seen || next >= limit || next > ENTRY_MAX)
                    r.table_full = 1'b1;
                else
                begin
                    n_entries      = next;
                    slot_tab[slot] = entry_t'(next);
                    key_tab[next]  = key;
                    found          = entry_t'(next);
                    r.was_added    = 1'b1;
                end
            end
            r.entry_index = found;
            pending_results.push_back(r);
        endfunction

        function void flag(string what, lookup_result_t want, lookup_result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected index %0d added %0b full %0b, got index %0d added %0b full %0b",
                         what, want.entry_index, want.was_added, want.table_full,
                         got.entry_index, got.was_added, got.table_full);
        endfunction

        function void check_result(lookup_result_t got);
            lookup_result_t want;
            if (pending_results.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
                flag("result mismatch", want, got);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    bit           steady;
    int unsigned  cycles;
    int unsigned  stall;
    key_t         sent_keys [$];
    table_tracker tracker;

    dht_cfg_if cfg_ch ();
    dht_in_if  req_ch ();
    dht_out_if rsp_ch ();

    double_hash_table_find_insert #(
        .TABLE_BITS (TABLE_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_result({rsp_ch.entry_index, rsp_ch.was_added, rsp_ch.table_full});
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, none while steady
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall        = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall == 0 && !steady && $urandom_range(0, 3) == 0)
                stall = pick_gap();
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                stall--;
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    // Leave valid high after the transaction; the next call drops or reuses it
    task automatic push_req(input logic kind, input key_t key);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.kind     = kind;
        req_ch.hash_key = key;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        tracker.note_request(kind, key);
        sent_keys.push_back(key);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input entry_t value);
        drain();
        @(negedge clk);
        cfg_ch.valid       = 1'b1;
        cfg_ch.entry_limit = value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        tracker.set_limit(value);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly hits and collisions against keys already seen, the rest fresh keys
    function automatic key_t make_key();
        int unsigned r;
        key_t        fresh;
        key_t        seen;
        fresh = {$urandom, $urandom};
        if (sent_keys.size() == 0)
            return fresh;
        seen = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        r    = $urandom_range(0, 99);
        if (r < 30)
            return seen;
        if (r < 45)
            return {fresh[63:TABLE_BITS], seen[TABLE_BITS-1:0]};
        if (r < 55)
            return {fresh[63:2*TABLE_BITS], seen[2*TABLE_BITS-1:0]};
        if (r < 60)
            return fresh & key_t'($urandom_range(0, 255));
        return fresh;
    endfunction

    initial
    begin
        entry_t      lim;
        int unsigned room;
        tracker            = new();
        cycles             = 0;
        steady             = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.entry_limit = '0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = 1'b0;
        req_ch.hash_key    = '0;
        rst_n              = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: misses, hits, collisions on home slot and on wrapped probes
        push_req(1'b0, 64'h0);
        push_req(1'b1, 64'h0);
        push_req(1'b1, 64'h0);
        push_req(1'b0, 64'h0);
        push_req(1'b1, '1);
        push_req(1'b0, '1);
        push_req(1'b1, 64'h0000_0001_0000_0000);
        push_req(1'b0, 64'h0000_0001_0000_0000);
        push_req(1'b1, 64'hFFFF_FFFF_FFFF_F000);
        push_req(1'b0, 64'hFFFF_FFFF_FFFF_F000);
        push_req(1'b0, 64'h0000_0002_0000_0000);

        // Limit of zero refuses every insert, hits still resolve
        write_limit(10'd0);
        push_req(1'b1, 64'h1234_5678_9ABC_DEF0);
        push_req(1'b1, 64'h0);
        push_req(1'b0, '1);
        write_limit(10'd1);
        push_req(1'b1, 64'h0FED_CBA9_8765_4321);
        push_req(1'b0, 64'h0FED_CBA9_8765_4321);
        // Insert up to the limit, then get refused
        write_limit(entry_t'(tracker.n_entries + 2));
        push_req(1'b1, 64'h5555_AAAA_5555_AAAA);
        push_req(1'b1, 64'hAAAA_5555_AAAA_5555);
        push_req(1'b0, 64'h5555_AAAA_5555_AAAA);
        write_limit(ENTRY_LIMIT_RST);
        push_req(1'b1, 64'hAAAA_5555_AAAA_5555);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
                lim = ENTRY_LIMIT_RST;
            else
            begin
                case ($urandom_range(0, 2))
                    0: lim = ENTRY_LIMIT_RST;
                    1:
                    begin
                        room = tracker.n_entries + $urandom_range(1, 40);
                        lim  = (room > 1023) ? ENTRY_LIMIT_RST : entry_t'(room);
                    end
                    default: lim = entry_t'($urandom_range(1, 1023));
                endcase
            end
            write_limit(lim);
            steady = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
                push_req($urandom_range(0, 3) != 0, make_key());
            steady = 1'b0;
        end

        drain();
        repeat (64) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ double_hash_table_find_insert.f @@
rtl/core/dht_pkg.sv
rtl/core/dht_if.sv
rtl/core/double_hash_table_find_insert.sv
rtl/core/dht_checker.sv
tb/tb_top.sv
